// ===== sv/tqst_pkg.sv =====
// ----------------------------------------------------------------------------
// tqst_pkg
// Shared types and constants for the timer query slot tracker.
// ----------------------------------------------------------------------------
package tqst_pkg;

    localparam int RING_SIZE_DEF   = 4;
    localparam int STAMP_WIDTH_DEF = 32;
    localparam int CNT_W           = 32;
    localparam int ELAPSED_W       = 64;
    localparam int SLOT_W          = 2;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_END    = 2'd1,
        OP_TAKE   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_BEGUN     = 3'd1,
        ST_ENDED     = 3'd2,
        ST_NOFREE    = 3'd3,
        ST_TAKEN     = 3'd4,
        ST_NOTREADY  = 3'd5,
        ST_DISCARDED = 3'd6,
        ST_NONE      = 3'd7
    } t_status;

    typedef struct packed {
        t_opcode               opcode;
        logic                  result_ready;
        logic                  clock_disjoint;
        logic [ELAPSED_W-1:0]  elapsed_in;
    } t_in;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [ELAPSED_W-1:0]  elapsed_out;
        logic [CNT_W-1:0]      skipped_count;
        logic [CNT_W-1:0]      submitted_count;
        logic [CNT_W-1:0]      resolved_count;
        logic [CNT_W-1:0]      discarded_count;
    } t_out;

    typedef struct packed {
        logic accept;     // latch beat, restart oldest-stamp scan
        logic scan_step;  // examine one slot
        logic commit;     // apply operation, load result register
    } t_cmd;

    typedef struct packed {
        logic is_take;
        logic scan_last;
    } t_sts;

endpackage

// ===== sv/tqst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tqst_ctrl
// Sequencer: accepts a beat, runs the slot scan for take, commits the
// operation when the result register is free, and owns both handshakes.
// ----------------------------------------------------------------------------
module tqst_ctrl
    import tqst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign commit      = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);

    assign o_cmd.accept    = accept;
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.commit    = commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.is_take ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("second beat accepted while busy");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed result not presented");

    a_commit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after commit");

endmodule

// ===== sv/tqst_dp.sv =====
// ----------------------------------------------------------------------------
// tqst_dp
// Slot state, stamps, counters, oldest-stamp scan and result register.
// ----------------------------------------------------------------------------
module tqst_dp
    import tqst_pkg::*;
#(
    parameter int RING_SIZE   = RING_SIZE_DEF,
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_in  i_in,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    output t_out o_out
);

    localparam int IW = $clog2(RING_SIZE);
    localparam logic [IW:0]   RING_W = (IW+1)'(RING_SIZE);
    localparam logic [IW-1:0] LAST   = IW'(RING_SIZE - 1);

    logic                   r_enabled;
    t_in                    r_item;
    logic [RING_SIZE-1:0]   r_pend, n_pend;
    logic [STAMP_WIDTH-1:0] r_stamp [RING_SIZE];
    logic                   r_act_v, n_act_v;
    logic [IW-1:0]          r_act_slot, n_act_slot;
    logic [IW-1:0]          r_wp, n_wp;
    logic [STAMP_WIDTH-1:0] r_next_stamp, n_next_stamp;
    logic [CNT_W-1:0]       r_skip, n_skip;
    logic [CNT_W-1:0]       r_submit, n_submit;
    logic [CNT_W-1:0]       r_resolve, n_resolve;
    logic [CNT_W-1:0]       r_discard, n_discard;
    logic [IW-1:0]          r_scan_idx;
    logic                   r_best_v;
    logic [IW-1:0]          r_best_idx;
    logic [STAMP_WIDTH-1:0] r_best_stamp;
    t_out                   r_out, n_out;

    logic [STAMP_WIDTH-1:0] scan_stamp;
    logic                   stamp_we;
    logic [IW:0]            cand;
    logic                   free_found;
    logic [IW-1:0]          free_slot;
    logic [IW:0]            wp_inc;

    assign o_sts.is_take   = (i_in.opcode == OP_TAKE);
    assign o_sts.scan_last = (r_scan_idx == LAST);
    assign o_out           = r_out;
    assign scan_stamp      = r_stamp[r_scan_idx];

    // rotating first-free search from the write pointer
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        cand       = '0;
        for (int k = RING_SIZE - 1; k >= 0; k--) begin
            cand = {1'b0, r_wp} + (IW+1)'(k);
            if (cand >= RING_W) begin
                cand = cand - RING_W;
            end
            if (!r_pend[cand[IW-1:0]]) begin
                free_found = 1'b1;
                free_slot  = cand[IW-1:0];
            end
        end
    end

    assign wp_inc = {1'b0, free_slot} + (IW+1)'(1);

    always_comb begin
        n_pend       = r_pend;
        n_act_v      = r_act_v;
        n_act_slot   = r_act_slot;
        n_wp         = r_wp;
        n_next_stamp = r_next_stamp;
        n_skip       = r_skip;
        n_submit     = r_submit;
        n_resolve    = r_resolve;
        n_discard    = r_discard;
        stamp_we     = 1'b0;
        n_out        = '0;
        n_out.status = ST_IGNORED;
        if (r_enabled) begin
            unique case (r_item.opcode)
                OP_BEGIN: begin
                    if (!r_act_v) begin
                        if (free_found) begin
                            n_act_v      = 1'b1;
                            n_act_slot   = free_slot;
                            n_wp         = (wp_inc == RING_W) ? '0 : wp_inc[IW-1:0];
                            n_out.status = ST_BEGUN;
                            n_out.slot   = SLOT_W'(free_slot);
                        end else begin
                            n_skip       = r_skip + 1'b1;
                            n_out.status = ST_NOFREE;
                        end
                    end
                end
                OP_END: begin
                    if (r_act_v) begin
                        n_pend[r_act_slot] = 1'b1;
                        stamp_we           = 1'b1;
                        n_next_stamp       = r_next_stamp + 1'b1;
                        n_submit           = r_submit + 1'b1;
                        n_act_v            = 1'b0;
                        n_out.status       = ST_ENDED;
                        n_out.slot         = SLOT_W'(r_act_slot);
                    end
                end
                OP_TAKE: begin
                    if (!r_best_v) begin
                        n_out.status = ST_NONE;
                    end else begin
                        n_out.slot = SLOT_W'(r_best_idx);
                        if (!r_item.result_ready) begin
                            n_out.status = ST_NOTREADY;
                        end else begin
                            n_pend[r_best_idx] = 1'b0;
                            if (r_item.clock_disjoint) begin
                                n_discard    = r_discard + 1'b1;
                                n_out.status = ST_DISCARDED;
                            end else begin
                                n_resolve         = r_resolve + 1'b1;
                                n_out.status      = ST_TAKEN;
                                n_out.elapsed_out = r_item.elapsed_in;
                            end
                        end
                    end
                end
                default: n_out.status = ST_IGNORED;
            endcase
        end
        n_out.skipped_count   = n_skip;
        n_out.submitted_count = n_submit;
        n_out.resolved_count  = n_resolve;
        n_out.discarded_count = n_discard;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
        if (i_cmd.commit && stamp_we) begin
            r_stamp[r_act_slot] <= r_next_stamp;
        end
        if (i_cmd.scan_step) begin
            if (r_pend[r_scan_idx] && (!r_best_v || scan_stamp < r_best_stamp)) begin
                r_best_idx   <= r_scan_idx;
                r_best_stamp <= scan_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b1;
            r_pend       <= '0;
            r_act_v      <= 1'b0;
            r_act_slot   <= '0;
            r_wp         <= '0;
            r_next_stamp <= '0;
            r_skip       <= '0;
            r_submit     <= '0;
            r_resolve    <= '0;
            r_discard    <= '0;
            r_scan_idx   <= '0;
            r_best_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_scan_idx <= '0;
                r_best_v   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_pend[r_scan_idx]) begin
                    r_best_v <= 1'b1;
                end
                r_scan_idx <= (r_scan_idx == LAST) ? '0 : r_scan_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_pend       <= n_pend;
                r_act_v      <= n_act_v;
                r_act_slot   <= n_act_slot;
                r_wp         <= n_wp;
                r_next_stamp <= n_next_stamp;
                r_skip       <= n_skip;
                r_submit     <= n_submit;
                r_resolve    <= n_resolve;
                r_discard    <= n_discard;
            end
        end
    end

    a_active_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_v |-> !r_pend[r_act_slot])
        else $error("active slot is also pending");

    a_taken_zero_else: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_out.status != ST_TAKEN) |=> (r_out.elapsed_out == '0))
        else $error("elapsed reported without a take");

endmodule

// ===== sv/timer_query_slot_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// timer_query_slot_tracker_unit
// Ring of timer measurement slots driven by begin, end and take operations.
//
// Input channel i_in (valid/ready) carries one operation per beat; output
// channel o_out (valid/ready) returns exactly one result beat per operation,
// in order. i_cfg_we/i_cfg_data write the enable bit; write only while idle.
// Begin and end go from the accepted beat straight to the write state, which
// commits the result to the output register. Take first walks the slots one
// per cycle to find the oldest stamp, then goes to the write state.
// One operation is in flight at a time; the next beat is accepted once the
// previous result sits in the output register, even if the receiver has not
// taken it. A stalled receiver holds the result register and, after at most
// one further operation, holds off the input channel.
// Reset (synchronous, active low) frees all slots, clears the counters,
// the stamp counter and the write pointer, and sets the enable bit.
// ----------------------------------------------------------------------------
module timer_query_slot_tracker_unit
    import tqst_pkg::*;
#(
    parameter int RING_SIZE   = RING_SIZE_DEF,
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out,
    input  logic i_cfg_we,
    input  logic i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    tqst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tqst_dp #(
        .RING_SIZE   (RING_SIZE),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer query slot tracker.
//
// A directed table covers the corner cases first: take with nothing
// pending, stray end, unused opcode, double begin, a full ring, not-ready,
// discard, and the disabled state. Rows with an obvious answer carry it
// inline; the rest are predicted. Random begin/end/take traffic follows in
// phases with different result-ready rates and enable settings, and every
// result beat is compared field by field against an in-bench slot model.
// Stamp width is set to 8 bits so the submission number wraps during the run.
// ----------------------------------------------------------------------------
module testbench;
    import tqst_pkg::*;

    localparam int RING    = RING_SIZE_DEF;
    localparam int STAMP_W = 8;
    localparam int LAT     = RING + 4;
    localparam int LIMIT   = 200000;
    localparam int N_PHASE = 6;

    localparam bit PHASE_EN    [N_PHASE] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam int PHASE_READY [N_PHASE] = '{60, 90, 30, 50, 50, 75};

    typedef struct packed {
        bit   is_cfg;
        bit   cfg_val;
        t_in  beat;
        bit   has_fix;
        t_out fix;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_data  = 1'b0;

    t_out result_q [$];
    t_row dir_rows [$];
    int   mismatch_n = 0;
    int   cycle_n    = 0;
    bit   quiet      = 1'b0;

    // slot model state
    logic               slot_pending [RING];
    logic [STAMP_W-1:0] slot_stamp   [RING];
    logic               open_valid;
    logic [SLOT_W-1:0]  open_slot;
    logic [SLOT_W-1:0]  free_ptr;
    logic [STAMP_W-1:0] stamp_ctr;
    logic [CNT_W-1:0]   n_skip, n_submit, n_resolve, n_discard;
    logic               tracker_en;

    timer_query_slot_tracker_unit #(
        .RING_SIZE   (RING),
        .STAMP_WIDTH (STAMP_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_tracker();
        for (int k = 0; k < RING; k++) begin
            slot_pending[k] = 1'b0;
            slot_stamp[k]   = '0;
        end
        open_valid = 1'b0;
        open_slot  = '0;
        free_ptr   = '0;
        stamp_ctr  = '0;
        n_skip     = '0;
        n_submit   = '0;
        n_resolve  = '0;
        n_discard  = '0;
        tracker_en = 1'b1;
    endfunction

    function automatic t_out track_op(t_in b);
        t_out              r;
        int                pick;
        logic [SLOT_W-1:0] s;
        r    = '0;
        pick = -1;
        if (tracker_en) begin
            case (b.opcode)
                OP_BEGIN: if (!open_valid) begin
                    for (int off = 0; off < RING; off++) begin
                        s = SLOT_W'((int'(free_ptr) + off) % RING);
                        if (pick < 0 && !slot_pending[s] && !(open_valid && s == open_slot))
                            pick = s;
                    end
                    if (pick < 0) begin
                        n_skip++;
                        r.status = ST_NOFREE;
                    end else begin
                        free_ptr   = SLOT_W'((pick + 1) % RING);
                        open_valid = 1'b1;
                        open_slot  = SLOT_W'(pick);
                        r.status   = ST_BEGUN;
                        r.slot     = SLOT_W'(pick);
                    end
                end
                OP_END: if (open_valid) begin
                    slot_pending[open_slot] = 1'b1;
                    slot_stamp[open_slot]   = stamp_ctr;
                    stamp_ctr++;
                    n_submit++;
                    open_valid = 1'b0;
                    r.status   = ST_ENDED;
                    r.slot     = open_slot;
                end
                OP_TAKE: begin
                    // equal stamps: lowest index wins
                    for (int k = 0; k < RING; k++)
                        if (slot_pending[k] && (pick < 0 || slot_stamp[k] < slot_stamp[pick]))
                            pick = k;
                    if (pick < 0) begin
                        r.status = ST_NONE;
                    end else begin
                        r.slot = SLOT_W'(pick);
                        if (!b.result_ready) begin
                            r.status = ST_NOTREADY;
                        end else begin
                            slot_pending[pick] = 1'b0;
                            if (b.clock_disjoint) begin
                                n_discard++;
                                r.status = ST_DISCARDED;
                            end else begin
                                n_resolve++;
                                r.status      = ST_TAKEN;
                                r.elapsed_out = b.elapsed_in;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        r.skipped_count   = n_skip;
        r.submitted_count = n_submit;
        r.resolved_count  = n_resolve;
        r.discarded_count = n_discard;
        return r;
    endfunction

    function automatic void add_row(t_opcode op, bit rdy, bit dis, logic [63:0] el,
                                    bit has_fix = 1'b0, t_out fx = '0);
        t_row w;
        w         = '0;
        w.beat    = '{op, rdy, dis, el};
        w.has_fix = has_fix;
        w.fix     = fx;
        dir_rows.push_back(w);
    endfunction

    function automatic void add_cfg(bit v);
        t_row w;
        w         = '0;
        w.is_cfg  = 1'b1;
        w.cfg_val = v;
        dir_rows.push_back(w);
    endfunction

    function automatic t_in rand_beat(int ready_pct);
        t_in b;
        int  r;
        r = $urandom_range(99);
        if (r < 5)
            b.opcode = t_opcode'($urandom_range(3));
        else if (r < 35)
            b.opcode = OP_TAKE;
        else
            b.opcode = open_valid ? OP_END : OP_BEGIN;
        b.result_ready   = $urandom_range(99) < ready_pct;
        b.clock_disjoint = $urandom_range(3) == 0;
        case ($urandom_range(7))
            0:       b.elapsed_in = '0;
            1:       b.elapsed_in = '1;
            default: b.elapsed_in = {$urandom, $urandom};
        endcase
        return b;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatch_n++;
        end
    endfunction

    task automatic send_beat(input t_in b, input bit has_fix, input t_out fix,
                             output t_status st);
        t_out pred;
        while (!quiet && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pred = track_op(b);
        result_q.push_back(has_fix ? fix : pred);
        st = pred.status;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (result_q.size() > 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker_en = v;
    endtask

    initial begin
        t_status st;
        int      done_n;
        clear_tracker();

        add_cfg(1'b1);
        add_row(OP_TAKE,   1'b1, 1'b0, '1, 1'b1, t_out'{ST_NONE, 2'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(OP_END,    1'b0, 1'b0, '0, 1'b1, t_out'{ST_IGNORED, 2'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(OP_UNUSED, 1'b1, 1'b1, '1, 1'b1, t_out'{ST_IGNORED, 2'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(OP_BEGIN,  1'b0, 1'b0, '0, 1'b1, t_out'{ST_BEGUN, 2'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(OP_BEGIN,  1'b0, 1'b0, '0, 1'b1, t_out'{ST_IGNORED, 2'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(OP_END,    1'b0, 1'b0, '0, 1'b1, t_out'{ST_ENDED, 2'd0, 64'd0, 32'd0, 32'd1, 32'd0, 32'd0});
        add_row(OP_TAKE,   1'b0, 1'b0, '1, 1'b1, t_out'{ST_NOTREADY, 2'd0, 64'd0, 32'd0, 32'd1, 32'd0, 32'd0});
        add_row(OP_TAKE,   1'b1, 1'b0, '1, 1'b1, t_out'{ST_TAKEN, 2'd0, '1, 32'd0, 32'd1, 32'd1, 32'd0});
        add_row(OP_BEGIN,  1'b0, 1'b0, '0, 1'b1, t_out'{ST_BEGUN, 2'd1, 64'd0, 32'd0, 32'd1, 32'd1, 32'd0});
        add_row(OP_END,    1'b0, 1'b0, '0, 1'b1, t_out'{ST_ENDED, 2'd1, 64'd0, 32'd0, 32'd2, 32'd1, 32'd0});
        // fill the ring, then one begin too many
        for (int k = 0; k < RING - 1; k++) begin
            add_row(OP_BEGIN, 1'b0, 1'b0, '0);
            add_row(OP_END,   1'b0, 1'b0, '0);
        end
        add_row(OP_BEGIN, 1'b0, 1'b0, '0);
        add_row(OP_TAKE,  1'b0, 1'b1, '1);
        add_row(OP_TAKE,  1'b1, 1'b1, '1);
        add_row(OP_TAKE,  1'b1, 1'b0, '0);
        add_row(OP_TAKE,  1'b1, 1'b0, 64'h8000_0000_0000_0001);
        add_row(OP_TAKE,  1'b1, 1'b1, 64'h7fff_ffff_ffff_fffe);
        add_row(OP_TAKE,  1'b1, 1'b0, '1);
        add_cfg(1'b0);
        add_row(OP_BEGIN,  1'b0, 1'b0, '0);
        add_row(OP_END,    1'b0, 1'b0, '0);
        add_row(OP_TAKE,   1'b1, 1'b0, '1);
        add_row(OP_UNUSED, 1'b1, 1'b1, '1);
        add_cfg(1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_enable(dir_rows[k].cfg_val);
            else
                send_beat(dir_rows[k].beat, dir_rows[k].has_fix, dir_rows[k].fix, st);
        end

        for (int p = 0; p < N_PHASE; p++) begin
            write_enable(PHASE_EN[p]);
            quiet  = (p == 2);
            done_n = 0;
            while (done_n < (PHASE_EN[p] ? 230 : 40)) begin
                send_beat(rand_beat(PHASE_READY[p]), 1'b0, '0, st);
                if (st != ST_IGNORED || !PHASE_EN[p])
                    done_n++;
            end
        end
        quiet = 1'b0;
        settle();

        if (mismatch_n == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        t_out want;
        cycle_n++;
        i_out_ready <= quiet || $urandom_range(99) >= 7;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out);
                mismatch_n++;
            end else begin
                want = result_q.pop_front();
                check_field("status",          want.status,          o_out.status);
                check_field("slot",            want.slot,            o_out.slot);
                check_field("elapsed_out",     want.elapsed_out,     o_out.elapsed_out);
                check_field("skipped_count",   want.skipped_count,   o_out.skipped_count);
                check_field("submitted_count", want.submitted_count, o_out.submitted_count);
                check_field("resolved_count",  want.resolved_count,  o_out.resolved_count);
                check_field("discarded_count", want.discarded_count, o_out.discarded_count);
            end
        end
        if (cycle_n >= LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== timer_query_slot_tracker_unit.f =====
sv/tqst_pkg.sv
sv/tqst_ctrl.sv
sv/tqst_dp.sv
sv/timer_query_slot_tracker_unit.sv
test/testbench.sv
